// ===== rtl/tlb_lfu_page_translate_assert.svh =====
// Assertion macros shared by the translation block.
`ifndef TLB_LFU_PAGE_TRANSLATE_ASSERT_SVH
`define TLB_LFU_PAGE_TRANSLATE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TLBL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlbl assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define TLBL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlbl assertion failed");

`endif

// ===== rtl/tlbl_pkg.sv =====
// Package: types, command codes and helpers for the TLB / page table translator.
`timescale 1ns / 1ps
`default_nettype none

package tlbl_pkg;

  localparam int TLB_ENTRIES_DEF = 4;
  localparam int PT_ENTRIES_DEF  = 16;
  localparam int OFFSET_BITS_DEF = 12;

  localparam int ADDR_W  = 32;
  localparam int PAGE_W  = 20;
  localparam int COUNT_W = 16;
  localparam int SLOT_W  = 4;
  localparam int CMD_W   = 2;
  localparam int SLOT_SPAN = 2 ** SLOT_W;

  localparam logic [CMD_W-1:0] CMD_TRANSLATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_PT   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD_TLB  = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef struct packed {
    logic [PAGE_W-1:0]  vpn;
    logic [PAGE_W-1:0]  ppn;
    logic [COUNT_W-1:0] uses;
  } pt_entry_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    sat_inc = (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/tlb_lfu_page_translate.sv =====
// Top level: TLB with least-frequently-used refill in front of a linearly walked page table.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------------
//   in      | input     | in_valid / in_ready  | cmd, vaddr, slot, entry_vpn/ppn/count
//   out     | output    | out_valid / out_ready| ok, paddr, tlb_hit
//
// Loads are written as they are accepted. A translate on a TLB hit passes accept,
// parallel tag compare and result; on a miss it walks k page table entries through
// the single read port, one per cycle (k at most min(PT_ENTRIES,16)), then refills
// the TLB on a page table hit or returns a miss when no entry matches.
// The refill waits on the victim scan, one TLB slot per cycle, when TLB_ENTRIES
// exceeds k + 1. Reset clears all valid bits at once; no clearing pass.
// A finished result sits in the output register; loads are still taken meanwhile,
// and a later translate holds its result until the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

`include "tlb_lfu_page_translate_assert.svh"

module tlb_lfu_page_translate
  import tlbl_pkg::*;
#(
  parameter int TLB_ENTRIES = TLB_ENTRIES_DEF,
  parameter int PT_ENTRIES  = PT_ENTRIES_DEF,
  parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire  [CMD_W-1:0]    cmd,
  input  wire  [ADDR_W-1:0]   vaddr,
  input  wire  [SLOT_W-1:0]   slot,
  input  wire  [PAGE_W-1:0]   entry_vpn,
  input  wire  [PAGE_W-1:0]   entry_ppn,
  input  wire  [COUNT_W-1:0]  entry_count,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic                ok,
  output logic [ADDR_W-1:0]   paddr,
  output logic                tlb_hit
);

  // only slots reachable by the 4-bit load index are ever stored
  localparam int PT_DEPTH = (PT_ENTRIES < SLOT_SPAN) ? PT_ENTRIES : SLOT_SPAN;
  localparam int PT_IW    = (PT_DEPTH > 1) ? $clog2(PT_DEPTH) : 1;
  localparam int TLB_IW   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int VPN_W    = ADDR_W - OFFSET_BITS;
  localparam int CMP_W    = (VPN_W > PAGE_W) ? VPN_W : PAGE_W;
  localparam int PA_W     = PAGE_W + OFFSET_BITS;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOOKUP = 3'd1;
  localparam logic [2:0] ST_WALK   = 3'd2;
  localparam logic [2:0] ST_FILL   = 3'd3;
  localparam logic [2:0] ST_DONE   = 3'd4;

  logic [2:0] state;

  logic [PAGE_W-1:0]  tlb_vpn  [TLB_ENTRIES];
  logic [PAGE_W-1:0]  tlb_ppn  [TLB_ENTRIES];
  logic [COUNT_W-1:0] tlb_uses [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] tlb_valid;

  pt_entry_t          pt_mem [PT_DEPTH];
  pt_entry_t          pt_rd;
  pt_entry_t          match_q;
  logic [PT_DEPTH-1:0] pt_valid;
  logic [PT_IW-1:0]   walk_idx;
  logic [PT_IW-1:0]   cmp_idx;

  logic [VPN_W-1:0]       vpn_q;
  logic [OFFSET_BITS-1:0] off_q;

  logic [TLB_IW-1:0]  vic_idx;
  logic [TLB_IW-1:0]  best_idx;
  logic [COUNT_W-1:0] best_cnt;
  logic               vic_done;

  logic              res_ok;
  logic [ADDR_W-1:0] res_paddr;
  logic              res_hit;

  logic               in_fire;
  logic               slot_in_pt;
  logic               slot_in_tlb;
  logic               pt_we;
  logic               hit_any;
  logic [TLB_IW-1:0]  hit_idx;
  logic               pt_match;
  logic               pt_last;
  logic               walk_last;
  logic               vic_last;
  logic [COUNT_W-1:0] vic_cnt;
  logic               scan_active;
  logic               out_free;

  function automatic logic [ADDR_W-1:0] make_paddr(input logic [PAGE_W-1:0] ppn,
                                                   input logic [OFFSET_BITS-1:0] off);
    logic [PA_W-1:0] cat;
    cat = {ppn, off};
    make_paddr = ADDR_W'(cat);
  endfunction

  assign in_ready    = (state == ST_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign slot_in_pt  = ({1'b0, slot} < (SLOT_W+1)'(PT_DEPTH));
  assign slot_in_tlb = ({1'b0, slot} < (SLOT_W+1)'(TLB_ENTRIES));
  assign pt_we       = in_fire && (cmd == CMD_LOAD_PT) && slot_in_pt;
  assign out_free    = !out_valid || out_ready;

  // parallel tag compare; lowest matching slot wins
  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (tlb_valid[i] && (CMP_W'(tlb_vpn[i]) == CMP_W'(vpn_q))) begin
        hit_any = 1'b1;
        hit_idx = TLB_IW'(i);
      end
    end
  end

  assign pt_match    = pt_valid[cmp_idx] && (CMP_W'(pt_rd.vpn) == CMP_W'(vpn_q));
  assign pt_last     = (cmp_idx == PT_IW'(PT_DEPTH - 1));
  assign walk_last   = (walk_idx == PT_IW'(PT_DEPTH - 1));
  assign vic_last    = (vic_idx == TLB_IW'(TLB_ENTRIES - 1));
  assign vic_cnt     = tlb_valid[vic_idx] ? tlb_uses[vic_idx] : '0;
  assign scan_active = (state == ST_LOOKUP) || (state == ST_WALK) || (state == ST_FILL);

  // page table storage, registered read; cmp_idx tags the data in pt_rd
  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[slot[PT_IW-1:0]] <= '{vpn: entry_vpn, ppn: entry_ppn, uses: entry_count};
    end
    pt_rd   <= pt_mem[walk_idx];
    cmp_idx <= walk_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tlb_valid <= '0;
      pt_valid  <= '0;
      out_valid <= 1'b0;
      vic_done  <= 1'b0;
    end else begin
      // the done state reloads the output register itself
      if (out_valid && out_ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end

      // victim scan runs alongside lookup, walk and fill, one slot per cycle
      if (scan_active && !vic_done) begin
        if ((vic_idx == '0) || (vic_cnt < best_cnt)) begin
          best_idx <= vic_idx;
          best_cnt <= vic_cnt;
        end
        if (vic_last) begin
          vic_done <= 1'b1;
        end else begin
          vic_idx <= vic_idx + 1'b1;
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            case (cmd)
              CMD_TRANSLATE: begin
                vpn_q    <= vaddr[ADDR_W-1:OFFSET_BITS];
                off_q    <= vaddr[OFFSET_BITS-1:0];
                walk_idx <= '0;
                vic_idx  <= '0;
                vic_done <= 1'b0;
                state    <= ST_LOOKUP;
              end
              CMD_LOAD_PT: begin
                if (slot_in_pt) begin
                  pt_valid[slot[PT_IW-1:0]] <= 1'b1;
                end
              end
              CMD_LOAD_TLB: begin
                if (slot_in_tlb) begin
                  tlb_vpn[slot[TLB_IW-1:0]]   <= entry_vpn;
                  tlb_ppn[slot[TLB_IW-1:0]]   <= entry_ppn;
                  tlb_uses[slot[TLB_IW-1:0]]  <= entry_count;
                  tlb_valid[slot[TLB_IW-1:0]] <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_LOOKUP: begin
          if (hit_any) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
              if (hit_idx == TLB_IW'(i)) begin
                tlb_uses[i] <= sat_inc(tlb_uses[i]);
              end
            end
            res_ok    <= 1'b1;
            res_paddr <= make_paddr(tlb_ppn[hit_idx], off_q);
            res_hit   <= 1'b1;
            state     <= ST_DONE;
          end else begin
            if (!walk_last) begin
              walk_idx <= walk_idx + 1'b1;
            end
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (pt_match) begin
            match_q <= pt_rd;
            state   <= ST_FILL;
          end else if (pt_last) begin
            res_ok    <= 1'b0;
            res_paddr <= '0;
            res_hit   <= 1'b0;
            state     <= ST_DONE;
          end else if (!walk_last) begin
            walk_idx <= walk_idx + 1'b1;
          end
        end
        ST_FILL: begin
          if (vic_done) begin
            tlb_vpn[best_idx]   <= match_q.vpn;
            tlb_ppn[best_idx]   <= match_q.ppn;
            tlb_uses[best_idx]  <= sat_inc(match_q.uses);
            tlb_valid[best_idx] <= 1'b1;
            res_ok    <= 1'b1;
            res_paddr <= make_paddr(match_q.ppn, off_q);
            res_hit   <= 1'b0;
            state     <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            ok        <= res_ok;
            paddr     <= res_paddr;
            tlb_hit   <= res_hit;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `TLBL_ASSERT_NOW(a_hit_is_ok, out_valid && tlb_hit, ok)
  `TLBL_ASSERT_NOW(a_miss_zero_paddr, out_valid && !ok, paddr == '0)
  `TLBL_ASSERT_NEXT(a_fill_sets_valid, (state == ST_FILL) && vic_done,
                    tlb_valid[$past(best_idx)])
  `TLBL_ASSERT_NEXT(a_done_delivers, (state == ST_DONE) && out_free,
                    out_valid && (ok == $past(res_ok)))

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for tlb_lfu_page_translate: directed and random traffic.
module tb;
  import tlbl_pkg::*;

  localparam int TLB_N = TLB_ENTRIES_DEF;
  localparam int PT_N  = PT_ENTRIES_DEF;
  localparam int OFF_W = OFFSET_BITS_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS    = 1000;
  localparam int POOL_N          = 12;
  localparam int HOLD_OFF_AT     = 300;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int IDLE_LIMIT      = 2000;
  localparam int PRINT_LIMIT     = 100;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [ADDR_W-1:0]  vaddr;
    logic [SLOT_W-1:0]  slot;
    logic [PAGE_W-1:0]  vpn;
    logic [PAGE_W-1:0]  ppn;
    logic [COUNT_W-1:0] count;
  } xlat_req_t;

  typedef struct packed {
    logic              ok;
    logic [ADDR_W-1:0] paddr;
    logic              hit;
  } xlat_rsp_t;

  typedef enum logic [1:0] {RX_STEADY, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic out_ready = 1'b0;
  logic in_ready, out_valid, ok, tlb_hit;
  logic [ADDR_W-1:0] paddr;
  xlat_req_t cur_item = '0;

  xlat_req_t req_q[$];
  xlat_rsp_t expected_xlat_q[$];

  // predicted page state
  logic [PAGE_W-1:0]  tlb_vpn_m[TLB_N] = '{default: '0};
  logic [PAGE_W-1:0]  tlb_ppn_m[TLB_N] = '{default: '0};
  logic [COUNT_W-1:0] tlb_uses_m[TLB_N] = '{default: '0};
  bit                 tlb_valid_m[TLB_N] = '{default: 1'b0};
  logic [PAGE_W-1:0]  pt_vpn_m[PT_N] = '{default: '0};
  logic [PAGE_W-1:0]  pt_ppn_m[PT_N] = '{default: '0};
  logic [COUNT_W-1:0] pt_uses_m[PT_N] = '{default: '0};
  bit                 pt_valid_m[PT_N] = '{default: 1'b0};

  int errors = 0;
  int accepted = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit in_taken = 1'b0;
  logic hold_off = 1'b0;
  int burst_left = 0;
  int gap_left = 0;
  int rx_left = 0;
  rx_mode_e rx_mode = RX_STEADY;
  logic rx_next;

  tlb_lfu_page_translate u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cur_item.cmd),
    .vaddr      (cur_item.vaddr),
    .slot       (cur_item.slot),
    .entry_vpn  (cur_item.vpn),
    .entry_ppn  (cur_item.ppn),
    .entry_count(cur_item.count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .paddr      (paddr),
    .tlb_hit    (tlb_hit)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] phys_addr(input logic [PAGE_W-1:0] ppn,
                                                  input logic [ADDR_W-1:0] offs);
    logic [63:0] wide;
    wide = (64'(ppn) << OFF_W) + 64'(offs);
    return wide[ADDR_W-1:0];
  endfunction

  // Applies one transfer to the predicted state and queues the translate result.
  task automatic track_page_state(input xlat_req_t r);
    logic [ADDR_W-1:0] page, offs;
    logic [COUNT_W-1:0] best_count, c;
    xlat_rsp_t rsp;
    int victim;
    bit done;
    done = 1'b0;
    rsp = '0;
    if (r.cmd == CMD_LOAD_PT) begin
      if (r.slot < PT_N) begin
        pt_vpn_m[r.slot] = r.vpn;
        pt_ppn_m[r.slot] = r.ppn;
        pt_uses_m[r.slot] = r.count;
        pt_valid_m[r.slot] = 1'b1;
      end
    end else if (r.cmd == CMD_LOAD_TLB) begin
      if (r.slot < TLB_N) begin
        tlb_vpn_m[r.slot] = r.vpn;
        tlb_ppn_m[r.slot] = r.ppn;
        tlb_uses_m[r.slot] = r.count;
        tlb_valid_m[r.slot] = 1'b1;
      end
    end else if (r.cmd == CMD_TRANSLATE) begin
      page = r.vaddr >> OFF_W;
      offs = r.vaddr & ((ADDR_W'(1) << OFF_W) - 1);
      for (int i = 0; i < TLB_N; i++) begin
        if (!done && tlb_valid_m[i] && ADDR_W'(tlb_vpn_m[i]) == page) begin
          tlb_uses_m[i] = count_up(tlb_uses_m[i]);
          rsp = '{ok: 1'b1, paddr: phys_addr(tlb_ppn_m[i], offs), hit: 1'b1};
          done = 1'b1;
        end
      end
      for (int i = 0; i < PT_N; i++) begin
        if (!done && pt_valid_m[i] && ADDR_W'(pt_vpn_m[i]) == page) begin
          // invalid slots count as zero; first lowest slot takes the refill
          victim = 0;
          best_count = tlb_valid_m[0] ? tlb_uses_m[0] : '0;
          for (int j = 1; j < TLB_N; j++) begin
            c = tlb_valid_m[j] ? tlb_uses_m[j] : '0;
            if (c < best_count) begin
              victim = j;
              best_count = c;
            end
          end
          tlb_vpn_m[victim] = pt_vpn_m[i];
          tlb_ppn_m[victim] = pt_ppn_m[i];
          tlb_uses_m[victim] = count_up(pt_uses_m[i]);
          tlb_valid_m[victim] = 1'b1;
          rsp = '{ok: 1'b1, paddr: phys_addr(pt_ppn_m[i], offs), hit: 1'b0};
          done = 1'b1;
        end
      end
      expected_xlat_q.push_back(rsp);
    end
  endtask

  task automatic report_mismatch(input string field, input logic [ADDR_W-1:0] got,
                                 input logic [ADDR_W-1:0] want);
    if (errors < PRINT_LIMIT)
      $display("[%0t] result %0d: %s got %h expected %h", $time, results_seen, field, got,
               want);
    errors++;
  endtask

  task automatic queue_item(input logic [CMD_W-1:0] c, input logic [ADDR_W-1:0] va,
                            input logic [SLOT_W-1:0] s, input logic [PAGE_W-1:0] vp,
                            input logic [PAGE_W-1:0] pp, input logic [COUNT_W-1:0] cnt);
    req_q.push_back('{cmd: c, vaddr: va, slot: s, vpn: vp, ppn: pp, count: cnt});
  endtask

  // sender: bursts with random gaps; gaps are suspended during the output hold-off
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (gap_left > 0 && !hold_off) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (req_q.size() != 0) begin
        cur_item <= req_q.pop_front();
        in_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end else begin
          burst_left--;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes mode at random intervals
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(8, 64);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        RX_STEADY: rx_next = 1'b1;
        RX_COIN:   rx_next = 1'($urandom_range(0, 1));
        RX_SPARSE: rx_next = ($urandom_range(0, 3) == 0);
        default:   rx_next = ($urandom_range(0, 7) != 0);
      endcase
      out_ready <= hold_off ? 1'b0 : rx_next;
    end
  end

  // long output hold-off so the result register fills and the input backs up
  initial begin
    wait (accepted >= HOLD_OFF_AT);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // transfer monitor, result check and watchdog
  always @(posedge clk) begin
    xlat_rsp_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        track_page_state(cur_item);
        in_taken = 1'b1;
        accepted++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_xlat_q.size() == 0) begin
          report_mismatch("unexpected result, paddr", paddr, '0);
        end else begin
          want = expected_xlat_q.pop_front();
          if (ok !== want.ok) report_mismatch("ok", ADDR_W'(ok), ADDR_W'(want.ok));
          if (paddr !== want.paddr) report_mismatch("paddr", paddr, want.paddr);
          if (tlb_hit !== want.hit)
            report_mismatch("tlb_hit", ADDR_W'(tlb_hit), ADDR_W'(want.hit));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
          $display("tlb_lfu_page_translate regression: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [PAGE_W-1:0] pool[POOL_N];
    xlat_req_t r;
    int effective;
    int pick;

    // directed: empty tables, saturation, duplicates, ignored loads, refill victims
    queue_item(CMD_TRANSLATE, 32'h0000_0000, 4'd0, '0, '0, '0);
    queue_item(CMD_TRANSLATE, 32'hFFFF_FFFF, 4'hF, '1, '1, '1);
    queue_item(CMD_LOAD_PT, 32'hFFFF_FFFF, 4'd0, 20'hFFFFF, 20'hFFFFF, 16'hFFFF);
    queue_item(CMD_LOAD_PT, 32'h0, 4'd15, 20'h00000, 20'h12345, 16'h0000);
    queue_item(CMD_LOAD_PT, 32'h0, 4'd1, 20'hFFFFF, 20'hABCDE, 16'h0005);
    queue_item(CMD_TRANSLATE, 32'hFFFF_FFFF, 4'd0, '0, '0, '0);
    queue_item(CMD_TRANSLATE, 32'hFFFF_F000, 4'd0, '0, '0, '0);
    queue_item(CMD_TRANSLATE, 32'h0000_0ABC, 4'd0, '0, '0, '0);
    queue_item(CMD_LOAD_TLB, 32'h0, 4'd2, 20'h00777, 20'h00000, 16'hFFFE);
    queue_item(CMD_LOAD_TLB, 32'h0, 4'd3, 20'h00777, 20'h55555, 16'h0003);
    queue_item(CMD_TRANSLATE, 32'h0077_7FFF, 4'd0, '0, '0, '0);
    queue_item(CMD_TRANSLATE, 32'h0077_7001, 4'd0, '0, '0, '0);
    queue_item(CMD_LOAD_TLB, 32'h0, 4'd4, 20'h00999, 20'h11111, 16'h0000);
    queue_item(CMD_LOAD_TLB, 32'h0, 4'd15, 20'h00999, 20'h22222, 16'h0000);
    queue_item(CMD_TRANSLATE, 32'h0099_9123, 4'd0, '0, '0, '0);
    queue_item(CMD_UNUSED, 32'h0099_9123, 4'd7, 20'h00999, 20'h33333, 16'h1234);
    queue_item(CMD_TRANSLATE, 32'h0099_9123, 4'd0, '0, '0, '0);
    queue_item(CMD_LOAD_PT, 32'h0, 4'd7, 20'h00999, 20'h00001, 16'hFFFE);
    queue_item(CMD_TRANSLATE, 32'h0099_9000, 4'd0, '0, '0, '0);
    queue_item(CMD_TRANSLATE, 32'h0000_0000, 4'd0, '0, '0, '0);
    queue_item(CMD_LOAD_TLB, 32'h0, 4'd0, 20'h12345, 20'hFEDCB, 16'h0000);
    queue_item(CMD_TRANSLATE, 32'h1234_5FFF, 4'd0, '0, '0, '0);
    queue_item(CMD_TRANSLATE, 32'hFFFF_F800, 4'd0, '0, '0, '0);

    // random: mostly translates of a small page pool so hits, refills and evictions mix
    foreach (pool[i]) pool[i] = PAGE_W'($urandom);
    effective = 0;
    while (effective < RANDOM_ITEMS) begin
      if ($urandom_range(0, 49) == 0) pool[$urandom_range(0, POOL_N - 1)] = PAGE_W'($urandom);
      pick = $urandom_range(0, 99);
      r.vaddr = $urandom;
      r.slot = SLOT_W'($urandom);
      r.vpn = pool[$urandom_range(0, POOL_N - 1)];
      r.ppn = PAGE_W'($urandom);
      r.count = COUNT_W'($urandom);
      if ($urandom_range(0, 9) == 0) r.count = COUNT_MAX - COUNT_W'($urandom_range(0, 1));
      else if ($urandom_range(0, 9) == 0) r.count = '0;
      if (pick < 60) begin
        r.cmd = CMD_TRANSLATE;
        if ($urandom_range(0, 4) != 0)
          r.vaddr[ADDR_W-1:OFF_W] = pool[$urandom_range(0, POOL_N - 1)];
        effective++;
      end else if (pick < 77) begin
        r.cmd = CMD_LOAD_PT;
        if ($urandom_range(0, 6) == 0) r.vpn = PAGE_W'($urandom);
        effective++;
      end else if (pick < 94) begin
        r.cmd = CMD_LOAD_TLB;
        if ($urandom_range(0, 4) != 0) r.slot = SLOT_W'($urandom_range(0, TLB_N - 1));
        if (r.slot < TLB_N) effective++;
      end else begin
        r.cmd = CMD_UNUSED;
      end
      req_q.push_back(r);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (req_q.size() == 0 && !in_valid);
    wait (expected_xlat_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("tlb_lfu_page_translate regression: pass");
    end else begin
      $display("tlb_lfu_page_translate regression: fail");
    end
    $finish;
  end

endmodule

// ===== tlb_lfu_page_translate.f =====
+incdir+rtl
rtl/tlbl_pkg.sv
rtl/tlb_lfu_page_translate.sv
sim/tb.sv
